### design/sdz_pkg.sv
// ----------------------------------------------------------------------------
// sdz_pkg
// shared types and constants for the sliding dot distance search
// ----------------------------------------------------------------------------
package sdz_pkg;

  localparam int unsigned MaxQuery  = 1024;
  localparam int unsigned MaxSeries = 1048576;
  localparam logic [31:0] BestStart = 32'd10000;

  localparam logic [1:0] CfgQueryLen = 2'd0;
  localparam logic [1:0] CfgQueryAvg = 2'd1;
  localparam logic [1:0] CfgQueryDev = 2'd2;

  typedef enum logic [2:0] {
    BkIdle,
    BkDot,
    BkMul,
    BkDiv,
    BkDone
  } bk_state_e;

  // request handed from front to back through the queue
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] wavg;
    logic [31:0] wdev;
    logic [9:0]  cidx;
    logic        load;
    logic        restart;
    logic        window;
  } sdz_req_t;

endpackage

### design/sdz_ram.sv
// ----------------------------------------------------------------------------
// sdz_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sdz_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/sdz_div.sv
// ----------------------------------------------------------------------------
// sdz_div
// signed 32 bit divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdz_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = num_i[31] ? 32'd0 - num_i : num_i;
      den_d  = den_i[31] ? 32'd0 - den_i : den_i;
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 32'd0 - quo_q : quo_q;

endmodule

### design/sdz_front.sv
// ----------------------------------------------------------------------------
// sdz_front
// accepts items, classifies loads and samples into requests
// ----------------------------------------------------------------------------
module sdz_front #(
  parameter int unsigned MaxQuery = sdz_pkg::MaxQuery
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        action_i,
  input  logic [9:0]                  coef_index_i,
  input  logic [31:0]                 sample_value_i,
  input  logic [31:0]                 window_avg_i,
  input  logic [31:0]                 window_dev_i,
  input  logic                        restart_i,
  output logic                        q_valid_o,
  output sdz_pkg::sdz_req_t           q_req_o,
  input  logic                        q_pop_i,
  output logic                        pend_restart_o
);

  // two entry queue
  sdz_pkg::sdz_req_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       acc, req_in, idx_ok;

  assign full_o = (cnt_q == 2'd2);
  assign acc    = push_i && !full_o;
  assign req_in = acc;
  assign idx_ok = ({22'd0, coef_index_i} < 32'(MaxQuery));

  assign q_valid_o      = (cnt_q != 2'd0);
  assign q_req_o        = ent_q[rd_q];
  assign pend_restart_o = 1'b0;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (req_in) begin
      wr_d = ~wr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_d = ~rd_q;
    end
    cnt_d = cnt_q + {1'b0, req_in} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_in) begin
      ent_q[wr_q] <= '{value: sample_value_i, wavg: window_avg_i, wdev: window_dev_i,
                       cidx: coef_index_i, load: !action_i && idx_ok,
                       restart: restart_i, window: action_i};
    end
  end

endmodule

### design/sdz_back.sv
// ----------------------------------------------------------------------------
// sdz_back
// runs the dot product, normalisation, division and running minimum
// ----------------------------------------------------------------------------
module sdz_back #(
  parameter int unsigned MaxQuery  = sdz_pkg::MaxQuery,
  parameter int unsigned MaxSeries = sdz_pkg::MaxSeries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  sdz_pkg::sdz_req_t           q_req_i,
  output logic                        q_pop_o,
  input  logic [10:0]                 query_len_i,
  input  logic [31:0]                 query_avg_i,
  input  logic [31:0]                 query_dev_i,
  output logic                        coef_we_o,
  output logic [$clog2(MaxQuery)-1:0] coef_waddr_o,
  output logic [31:0]                 coef_wdata_o,
  output logic [$clog2(MaxQuery)-1:0] coef_raddr_o,
  input  logic [31:0]                 coef_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_pop_i,
  output logic                        window_ready_o,
  output logic [19:0]                 window_index_o,
  output logic [31:0]                 dot_value_o,
  output logic [31:0]                 distance_value_o,
  output logic                        divide_fault_o,
  output logic [31:0]                 best_distance_o,
  output logic [19:0]                 best_index_o
);

  localparam int unsigned Aw = $clog2(MaxQuery);
  localparam int unsigned Cw = $clog2(MaxSeries + MaxQuery + 1);
  localparam logic [Cw-1:0] CntMax = Cw'(MaxSeries + MaxQuery);
  localparam logic [Cw-1:0] SerMax = Cw'(MaxSeries);

  sdz_pkg::bk_state_e st_q, st_d;

  logic [Aw-1:0]   head_q, head_d;
  logic [Cw-1:0]   scnt_q, scnt_d;
  logic [31:0]     best_q, best_d;
  logic [19:0]     bidx_q, bidx_d;
  logic [Aw:0]     len;
  logic [Aw:0]     step_q, step_d;
  logic [1:0]      phase_q, phase_d;
  logic [31:0]     dot_q, dot_d, prod_q, num_q, num_d, den_q, den_d;
  logic [31:0]     wavg_q, wdev_q, t1_q, t1_d;
  logic            win_q, win_d, fault_q, fault_d, pv_q, pv_d;
  logic [19:0]     widx_q, widx_d;
  logic [31:0]     dist_q, dist_d;
  logic            res_q, res_d;
  logic            div_start, div_done;
  logic [31:0]     div_quot;
  logic [31:0]     samp_rdata;
  logic            samp_we;
  logic [Aw-1:0]   samp_raddr;
  logic [Cw-1:0]   cnt_new;
  logic [Cw-1:0]   cnt_base;
  logic            out_win_q, out_flt_q;
  logic [19:0]     out_widx_q, out_bidx_q;
  logic [31:0]     out_dot_q, out_dist_q, out_best_q;

  // window length with saturation
  always_comb begin
    if (query_len_i == 11'd0) begin
      len = (Aw+1)'(1);
    end else if ({21'd0, query_len_i} > 32'(MaxQuery)) begin
      len = (Aw+1)'(MaxQuery);
    end else begin
      len = (Aw+1)'(query_len_i);
    end
  end

  sdz_ram #(.Width(32), .Depth(MaxQuery)) u_line (
    .clk_i  (clk_i),
    .we_i   (samp_we),
    .waddr_i(head_q),
    .wdata_i(q_req_i.value),
    .raddr_i(samp_raddr),
    .rdata_o(samp_rdata)
  );

  sdz_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign cnt_base = q_req_i.restart ? '0 : scnt_q;
  assign cnt_new  = (cnt_base < CntMax) ? cnt_base + Cw'(1) : cnt_base;

  // window start: oldest sample sits len places behind new head
  assign samp_raddr   = head_q - Aw'(len) + Aw'(step_q);
  assign coef_raddr_o = Aw'(step_q);
  assign coef_waddr_o = Aw'(q_req_i.cidx);
  assign coef_wdata_o = q_req_i.value;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sdz_pkg::BkIdle: begin
        if (q_valid_i) begin
          if (!q_req_i.window) begin
            st_d = sdz_pkg::BkIdle;
          end else if (cnt_new >= Cw'(len) && (cnt_new - Cw'(len)) < SerMax) begin
            st_d = sdz_pkg::BkDot;
          end else begin
            st_d = sdz_pkg::BkDone;
          end
        end
      end
      sdz_pkg::BkDot: begin
        if (!pv_q && step_q == len && phase_q == 2'd2) begin
          st_d = sdz_pkg::BkMul;
        end
      end
      sdz_pkg::BkMul: begin
        if (phase_q == 2'd2) begin
          st_d = (den_q == 32'd0) ? sdz_pkg::BkDone : sdz_pkg::BkDiv;
        end
      end
      sdz_pkg::BkDiv: begin
        if (div_done) begin
          st_d = sdz_pkg::BkDone;
        end
      end
      sdz_pkg::BkDone: begin
        if (!res_q) begin
          st_d = sdz_pkg::BkIdle;
        end
      end
      default: st_d = sdz_pkg::BkIdle;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    scnt_d    = scnt_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    step_d    = step_q;
    phase_d   = phase_q;
    dot_d     = dot_q;
    num_d     = num_q;
    den_d     = den_q;
    t1_d      = t1_q;
    win_d     = win_q;
    fault_d   = fault_q;
    pv_d      = 1'b0;
    widx_d    = widx_q;
    dist_d    = dist_q;
    res_d     = res_q;
    q_pop_o   = 1'b0;
    samp_we   = 1'b0;
    coef_we_o = 1'b0;
    div_start = 1'b0;
    if (res_q && res_pop_i) begin
      res_d = 1'b0;
    end
    unique case (st_q)
      sdz_pkg::BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_req_i.restart) begin
            scnt_d = '0;
            best_d = sdz_pkg::BestStart;
            bidx_d = '0;
          end
          if (q_req_i.load) begin
            coef_we_o = 1'b1;
          end
          if (q_req_i.window) begin
            samp_we = 1'b1;
            head_d  = head_q + Aw'(1);
            scnt_d  = cnt_new;
            win_d   = 1'b0;
            fault_d = 1'b0;
            widx_d  = '0;
            dot_d   = '0;
            dist_d  = '0;
            step_d  = '0;
            phase_d = '0;
            if (cnt_new >= Cw'(len) && (cnt_new - Cw'(len)) < SerMax) begin
              win_d  = 1'b1;
              widx_d = 20'(cnt_new - Cw'(len));
            end
          end
        end
      end
      sdz_pkg::BkDot: begin
        // issue read, then product, then accumulate
        if (step_q < len) begin
          step_d = step_q + (Aw+1)'(1);
          pv_d   = 1'b1;
        end
        if (pv_q) begin
          phase_d = 2'd1;
        end
        if (phase_q == 2'd1) begin
          dot_d = dot_q + prod_q;
        end
        if (!pv_q && phase_q == 2'd1) begin
          phase_d = 2'd2;
        end
        if (!pv_q && step_q == len && phase_q == 2'd2) begin
          phase_d = '0;
        end
      end
      sdz_pkg::BkMul: begin
        if (phase_q == 2'd0) begin
          t1_d    = 32'(len) * wavg_q;
          den_d   = wdev_q * query_dev_i;
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          num_d   = dot_q - t1_q * query_avg_i;
          phase_d = 2'd2;
        end else begin
          phase_d = '0;
          if (den_q == 32'd0) begin
            fault_d = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      sdz_pkg::BkDiv: begin
        if (div_done) begin
          dist_d = 32'(len) - div_quot;
          if ($signed(dist_d) < $signed(best_q)) begin
            best_d = dist_d;
            bidx_d = widx_q;
          end
        end
      end
      sdz_pkg::BkDone: begin
        if (!res_q) begin
          res_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sdz_pkg::BkIdle;
      head_q  <= '0;
      scnt_q  <= '0;
      best_q  <= sdz_pkg::BestStart;
      bidx_q  <= '0;
      step_q  <= '0;
      phase_q <= '0;
      pv_q    <= 1'b0;
      res_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      head_q  <= head_d;
      scnt_q  <= scnt_d;
      best_q  <= best_d;
      bidx_q  <= bidx_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      pv_q    <= pv_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    prod_q  <= samp_rdata * coef_rdata_i;
    num_q   <= num_d;
    den_q   <= den_d;
    t1_q    <= t1_d;
    win_q   <= win_d;
    fault_q <= fault_d;
    widx_q  <= widx_d;
    dist_q  <= dist_d;
    if (st_q == sdz_pkg::BkIdle && q_valid_i) begin
      wavg_q <= q_req_i.wavg;
      wdev_q <= q_req_i.wdev;
    end
  end

  // result register, frees the back end while a result waits
  always_ff @(posedge clk_i) begin
    if (st_q == sdz_pkg::BkDone && !res_q) begin
      out_win_q  <= win_q;
      out_widx_q <= widx_q;
      out_dot_q  <= dot_q;
      out_dist_q <= dist_q;
      out_flt_q  <= fault_q;
      out_best_q <= best_q;
      out_bidx_q <= bidx_q;
    end
  end

  assign res_valid_o      = res_q;
  assign window_ready_o   = out_win_q;
  assign window_index_o   = out_widx_q;
  assign dot_value_o      = out_dot_q;
  assign distance_value_o = out_dist_q;
  assign divide_fault_o   = out_flt_q;
  assign best_distance_o  = out_best_q;
  assign best_index_o     = out_bidx_q;

endmodule

### design/sliding_dot_znorm_min_search_top.sv
// ----------------------------------------------------------------------------
// sliding_dot_znorm_min_search_top
// z-normalised sliding dot distance with running minimum search
// per sample: take the request, dot product over L the used length, the products,
// serial divide, post the result; a zero divisor skips the divide and posts a fault,
// a sample without a window is posted with no dot product; samples go one at a time,
// further requests wait in the queue; loads one a cycle while the back end is idle
// reset clears counts, best to 10000, registers to their defaults
// ----------------------------------------------------------------------------
module sliding_dot_znorm_min_search_top #(
  parameter int unsigned MaxQuery  = sdz_pkg::MaxQuery,
  parameter int unsigned MaxSeries = sdz_pkg::MaxSeries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [9:0]  coef_index_i,
  input  logic [31:0] sample_value_i,
  input  logic [31:0] window_avg_i,
  input  logic [31:0] window_dev_i,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic        window_ready_o,
  output logic [19:0] window_index_o,
  output logic [31:0] dot_value_o,
  output logic [31:0] distance_value_o,
  output logic        divide_fault_o,
  output logic [31:0] best_distance_o,
  output logic [19:0] best_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned Aw = $clog2(MaxQuery);

  logic [10:0] qlen_q;
  logic [31:0] qavg_q, qdev_q;
  logic        coef_we, q_valid, q_pop, res_valid, pend;
  logic [Aw-1:0] coef_waddr, coef_raddr;
  logic [31:0] coef_wdata, coef_rdata;
  sdz_pkg::sdz_req_t q_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= 11'd1;
      qavg_q <= '0;
      qdev_q <= 32'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdz_pkg::CfgQueryLen: qlen_q <= cfg_data_i[10:0];
        sdz_pkg::CfgQueryAvg: qavg_q <= cfg_data_i;
        sdz_pkg::CfgQueryDev: qdev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdz_front #(.MaxQuery(MaxQuery)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .coef_index_i  (coef_index_i),
    .sample_value_i(sample_value_i),
    .window_avg_i  (window_avg_i),
    .window_dev_i  (window_dev_i),
    .restart_i     (restart_i),
    .q_valid_o     (q_valid),
    .q_req_o       (q_req),
    .q_pop_i       (q_pop),
    .pend_restart_o(pend)
  );

  sdz_ram #(.Width(32), .Depth(MaxQuery)) u_coef (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  sdz_back #(.MaxQuery(MaxQuery), .MaxSeries(MaxSeries)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid && !pend),
    .q_req_i         (q_req),
    .q_pop_o         (q_pop),
    .query_len_i     (qlen_q),
    .query_avg_i     (qavg_q),
    .query_dev_i     (qdev_q),
    .coef_we_o       (coef_we),
    .coef_waddr_o    (coef_waddr),
    .coef_wdata_o    (coef_wdata),
    .coef_raddr_o    (coef_raddr),
    .coef_rdata_i    (coef_rdata),
    .res_valid_o     (res_valid),
    .res_pop_i       (pop),
    .window_ready_o  (window_ready_o),
    .window_index_o  (window_index_o),
    .dot_value_o     (dot_value_o),
    .distance_value_o(distance_value_o),
    .divide_fault_o  (divide_fault_o),
    .best_distance_o (best_distance_o),
    .best_index_o    (best_index_o)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |=> empty)
    else $error("result stayed after being taken");
  a_fault_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && divide_fault_o) |-> (distance_value_o == 32'd0))
    else $error("fault with non-zero distance");
  a_ready_gates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !window_ready_o) |-> (dot_value_o == 32'd0 && !divide_fault_o))
    else $error("data without window");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sliding dot distance search: fills the low
// coefficients, runs a directed table, then random load and sample
// requests over several register settings, each result checked against the table or a
// local predictor of dot, distance and running minimum
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxQuery   = sdz_pkg::MaxQuery;
  localparam int unsigned MaxSeries  = sdz_pkg::MaxSeries;
  localparam logic [31:0] BestStart  = sdz_pkg::BestStart;
  localparam int unsigned FillLen    = 32;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic        act;
    logic [9:0]  cidx;
    logic [31:0] val;
    logic [31:0] wavg;
    logic [31:0] wdev;
    logic        rst;
  } sdz_item_t;

  typedef struct packed {
    logic        rdy;
    logic [19:0] widx;
    logic [31:0] dot;
    logic [31:0] distv;
    logic        flt;
    logic [31:0] best;
    logic [19:0] bidx;
  } sdz_res_t;

  typedef struct packed {
    sdz_item_t   it;
    logic        typed;
    sdz_res_t    res;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] len;
    logic [31:0] avg;
    logic [31:0] dev;
    logic [31:0] n;
  } phase_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic action_i, restart_i;
  logic [9:0] coef_index_i;
  logic [31:0] sample_value_i, window_avg_i, window_dev_i;
  logic window_ready_o, divide_fault_o;
  logic [19:0] window_index_o, best_index_o;
  logic [31:0] dot_value_o, distance_value_o, best_distance_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  sliding_dot_znorm_min_search_top dut (.*);

  // predictor state
  logic [10:0] q_len;
  logic [31:0] q_avg, q_dev;
  logic [31:0] coefs [MaxQuery];
  logic [31:0] line_buf [MaxQuery];
  int unsigned head, count;
  logic [31:0] min_dist;
  logic [19:0] min_idx;

  sdz_res_t pending[$];
  int unsigned errors, n_tx, n_rx, n_win, n_fault;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  int unsigned cycles;
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] div_zero_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic int unsigned used_len();
    if (q_len == 0) return 1;
    if (q_len > MaxQuery) return MaxQuery;
    return q_len;
  endfunction

  function automatic logic distance_step(sdz_item_t it, output sdz_res_t r);
    int unsigned len, pos;
    logic [31:0] den, num;
    r = '0;
    if (it.rst) begin
      count = 0;
      min_dist = BestStart;
      min_idx = '0;
    end
    if (!it.act) begin
      coefs[it.cidx] = it.val;
      return 1'b0;
    end
    len = used_len();
    line_buf[head] = it.val;
    head = (head + 1) % MaxQuery;
    if (count < MaxSeries + MaxQuery) count++;
    if (count >= len && count - len < MaxSeries) begin
      r.rdy = 1'b1;
      r.widx = 20'(count - len);
      for (int x = 0; x < len; x++) begin
        pos = (head + MaxQuery - len + x) % MaxQuery;
        r.dot = r.dot + line_buf[pos] * coefs[x];
      end
      den = it.wdev * q_dev;
      if (den == 0) begin
        r.flt = 1'b1;
      end else begin
        num = r.dot - 32'(len) * it.wavg * q_avg;
        r.distv = 32'(len) - div_zero_trunc(num, den);
        if ($signed(r.distv) < $signed(min_dist)) begin
          min_dist = r.distv;
          min_idx = r.widx;
        end
      end
    end
    r.best = min_dist;
    r.bidx = min_idx;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 20)) - 32'd10;
      1: return 32'($urandom_range(0, 300));
      2: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic sdz_item_t rand_item();
    sdz_item_t it;
    it.act = ($urandom_range(0, 99) < 85);
    it.cidx = 10'($urandom);
    it.val = pick_word();
    it.wavg = pick_word();
    case ($urandom_range(0, 9))
      0: it.wdev = '0;
      1: it.wdev = 32'h0001_0000;
      default: it.wdev = pick_word();
    endcase
    it.rst = ($urandom_range(0, 99) < 5);
    return it;
  endfunction

  task automatic send_item(sdz_item_t it, logic typed, sdz_res_t tres, int gap);
    sdz_res_t r;
    push <= 1'b1;
    action_i <= it.act;
    coef_index_i <= it.cidx;
    sample_value_i <= it.val;
    window_avg_i <= it.wavg;
    window_dev_i <= it.wdev;
    restart_i <= it.rst;
    do @(posedge clk_i); while (full);
    n_tx++;
    if (distance_step(it, r)) begin
      if (typed) r = tres;
      pending.push_back(r);
      if (r.rdy) n_win++;
      if (r.flt) n_fault++;
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      sdz_pkg::CfgQueryLen: q_len = data[10:0];
      sdz_pkg::CfgQueryAvg: q_avg = data;
      sdz_pkg::CfgQueryDev: q_dev = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (pending.size() == 0);
    repeat (used_len() + 100) @(posedge clk_i);
  endtask

  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // result side
  initial begin
    sdz_res_t e;
    int gap;
    pop = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (n_rx == 60) begin
        pop <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      n_rx++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual dist %h", $time,
                 distance_value_o);
        errors++;
      end else begin
        e = pending.pop_front();
        cmp("window_ready", 32'(e.rdy), 32'(window_ready_o));
        cmp("window_index", 32'(e.widx), 32'(window_index_o));
        cmp("dot_value", e.dot, dot_value_o);
        cmp("distance_value", e.distv, distance_value_o);
        cmp("divide_fault", 32'(e.flt), 32'(divide_fault_o));
        cmp("best_distance", e.best, best_distance_o);
        cmp("best_index", 32'(e.bidx), 32'(best_index_o));
      end
    end
  end

  dir_row_t rows[$];
  phase_t phases[$];

  initial begin
    sdz_item_t it;
    bit burst;
    errors = 0; n_tx = 0; n_rx = 0; n_win = 0; n_fault = 0;
    q_len = 11'd1; q_avg = '0; q_dev = 32'd1;
    head = 0; count = 0; min_dist = BestStart; min_idx = '0;
    foreach (line_buf[k]) line_buf[k] = '0;
    foreach (coefs[k]) coefs[k] = '0;
    push = 1'b0; action_i = 1'b0; coef_index_i = '0; sample_value_i = '0;
    window_avg_i = '0; window_dev_i = '0; restart_i = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = sdz_pkg::CfgQueryLen; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the coefficients that the longest window below reads
    for (int k = 0; k < FillLen; k++) begin
      it = '{act: 1'b0, cidx: 10'(k), val: pick_word(), wavg: $urandom,
             wdev: $urandom, rst: 1'b0};
      send_item(it, 1'b0, '0, 0);
    end

    // directed table at reset settings: length 1, mean 0, deviation 1
    rows.push_back('{'{1'b0, 10'd0, 32'd1, 32'd0, 32'd0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'd7, 32'd3, 32'd0, 1'b1}, 1'b1,
                     '{1'b1, 20'd0, 32'd7, 32'd0, 1'b1, BestStart, 20'd0}});
    rows.push_back('{'{1'b1, 10'd0, 32'd5, 32'd0, 32'd1, 1'b1}, 1'b1,
                     '{1'b1, 20'd0, 32'd5, -32'sd4, 1'b0, -32'sd4, 20'd0}});
    rows.push_back('{'{1'b1, 10'd0, 32'd5, 32'd0, 32'd1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0},
                     1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0},
                     1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1'b0},
                     1'b0, '0});
    rows.push_back('{'{1'b0, 10'd1023, 32'hffff_ffff, 32'h0, 32'h0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'd3, 32'd0, 32'd2, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, 10'd0, 32'd3, 32'd0, 32'd2, 1'b0}, 1'b0, '0});
    foreach (rows[k]) send_item(rows[k].it, rows[k].typed, rows[k].res, $urandom_range(0, 13));
    drain();

    // quotient overflow with length 1: dot of min over minus one
    write_reg(sdz_pkg::CfgQueryDev, 32'hffff_ffff);
    send_item('{1'b0, 10'd0, 32'd1, 32'd0, 32'd0, 1'b0}, 1'b0, '0, 0);
    send_item('{1'b1, 10'd0, 32'h8000_0000, 32'd0, 32'd1, 1'b1}, 1'b0, '0, 0);
    send_item('{1'b0, 10'd0, $urandom, 32'd0, 32'd0, 1'b0}, 1'b0, '0, 0);
    drain();

    phases.push_back('{32'd3, 32'd2, 32'd1, 32'd110});
    phases.push_back('{32'd0, 32'hffff_ffff, 32'd3, 32'd60});
    phases.push_back('{32'd8, 32'd7, -32'sd5, 32'd70});
    phases.push_back('{32'd16, 32'h7fff_ffff, 32'h8000_0000, 32'd50});
    phases.push_back('{32'd32, 32'h8000_0000, 32'h7fff_ffff, 32'd60});
    phases.push_back('{32'd5, 32'd0, 32'h0001_0000, 32'd60});
    phases.push_back('{32'd2, $urandom, $urandom, 32'd80});
    phases.push_back('{32'd1, 32'd0, 32'd1, 32'd45});
    foreach (phases[p]) begin
      write_reg(sdz_pkg::CfgQueryLen, phases[p].len);
      write_reg(sdz_pkg::CfgQueryAvg, phases[p].avg);
      write_reg(sdz_pkg::CfgQueryDev, phases[p].dev);
      burst = 1'b0;
      for (int k = 0; k < phases[p].n; k++) begin
        if ($urandom_range(0, 15) == 0) burst = ~burst;
        send_item(rand_item(), 1'b0, '0, draw_gap(burst));
      end
      drain();
    end

    $display("requests sent %0d, results checked %0d, windows %0d, zero divisors %0d",
             n_tx, n_rx, n_win, n_fault);
    $display("covered %0d register settings including zero length, mean and deviation extremes",
             phases.size() + 1);
    if (errors == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
